[src/rstd_pkg.sv]
package rstd_pkg;

  localparam int unsigned MaxColumnsDef = 64;

  typedef enum logic [2:0] {
    KIND_NULL      = 3'd0,
    KIND_INTEGER   = 3'd1,
    KIND_FLOAT     = 3'd2,
    KIND_BLOB      = 3'd3,
    KIND_TEXT      = 3'd4,
    KIND_RESERVED  = 3'd5,
    KIND_TRUNCATED = 3'd6
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_payload;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         column_index;
    logic [2:0]         kind;
    logic signed [63:0] int_value;
    logic [63:0]        float_bits;
    logic [30:0]        content_length;
    logic [31:0]        serial_type;
    logic               last_column;
  } out_item_t;

  // Body length of a serial type in bytes.
  function automatic logic [31:0] body_len(input logic [31:0] t);
    logic [31:0] r;
    r = 32'd0;
    if (t >= 32'd12) begin
      r = (t - 32'd12) >> 1;
    end else begin
      case (t[3:0])
        4'd1, 4'd2, 4'd3, 4'd4: r = {28'd0, t[3:0]};
        4'd5:                   r = 32'd6;
        4'd6, 4'd7:             r = 32'd8;
        default:                r = 32'd0;
      endcase
    end
    return r;
  endfunction

endpackage

[src/rstd_emit.sv]
// Result formatter: turns a stored serial type and the gathered body bits into
// one column result.
module rstd_emit
  import rstd_pkg::*;
(
  input  logic [31:0] type_i,
  input  logic [63:0] val_i,
  input  logic [5:0]  idx_i,
  input  logic        last_i,
  output out_item_t   item_o
);

  logic [31:0] len;
  logic [6:0]  bits;
  logic [63:0] ext;

  always_comb begin
    len  = body_len(type_i);
    bits = {len[3:0], 3'b000};
    ext  = val_i;
    if (bits < 7'd64 && bits != 7'd0) begin
      if (val_i[bits[5:0] - 6'd1]) begin
        ext = val_i | ~((64'd1 << bits[5:0]) - 64'd1);
      end
    end
    item_o                = '0;
    item_o.column_index   = idx_i;
    item_o.serial_type    = type_i;
    item_o.last_column    = last_i;
    item_o.kind           = KIND_RESERVED;
    if (type_i == 32'd0) begin
      item_o.kind = KIND_NULL;
    end else if (type_i <= 32'd6) begin
      item_o.kind      = KIND_INTEGER;
      item_o.int_value = ext;
    end else if (type_i == 32'd7) begin
      item_o.kind       = KIND_FLOAT;
      item_o.float_bits = val_i;
    end else if (type_i == 32'd8 || type_i == 32'd9) begin
      item_o.kind      = KIND_INTEGER;
      item_o.int_value = {63'd0, type_i[0]};
    end else if (type_i >= 32'd12) begin
      item_o.kind           = type_i[0] ? KIND_TEXT : KIND_BLOB;
      item_o.content_length = len[30:0];
    end
  end

endmodule

[src/record_serial_type_decoder.sv]
// Channel | Direction | Payload    | Handshake
// in      | input     | in_item_t  | in_valid_i / in_ready_o
// out     | output    | out_item_t | out_valid_o / out_ready_i
//
// One payload byte is taken per transfer. Each result is formed in the output
// register and waits there until out_ready_i is high; no byte is taken while it
// waits. A byte that completes the header or a column body leads through the
// emit states to set up the next column or the drain; zero-length columns are
// emitted in between.
// Reset clears the sequencer and counters; the store holds no reset value.
// The input is held off while a result waits to be taken or while the emit
// loop or a pending truncation result is still at work.
module record_serial_type_decoder
  import rstd_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = MaxColumnsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned IdxW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned CntW = $clog2(MAX_COLUMNS + 1);

  // Sequencer states. ADVANCE walks zero-length columns one at a time, each once the output register is free.
  typedef enum logic [5:0] {
    S_HSIZE   = 6'b000001,
    S_TYPES   = 6'b000010,
    S_BODY    = 6'b000100,
    S_DRAIN   = 6'b001000,
    S_ADVANCE = 6'b010000,
    S_TRUNC   = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  logic [63:0] vacc_q, vacc_d;
  logic [3:0]  vcnt_q, vcnt_d;
  logic [31:0] hleft_q, hleft_d;
  logic [CntW-1:0] ccount_q, ccount_d;
  logic [CntW-1:0] ccur_q, ccur_d;
  logic [31:0] bleft_q, bleft_d;
  logic [63:0] val_q, val_d;
  // Set when the end flag came while columns were still being emitted.
  logic        pend_end_q, pend_end_d;

  logic [31:0] store_q [MAX_COLUMNS];
  logic        wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [31:0] wr_data;
  // The store is read through a register, addressed by the next cursor.
  logic [IdxW-1:0] rd_idx;
  logic [31:0] rd_q;

  logic      ov_q;
  out_item_t od_q;
  logic      emit_v;
  out_item_t emit_item;
  out_item_t col_item;

  logic [31:0] cur_type;
  logic [31:0] cur_len;
  logic        take;

  assign rd_idx   = ccur_d[IdxW-1:0];
  assign cur_type = rd_q;
  assign cur_len  = body_len(cur_type);

  rstd_emit u_emit (
    .type_i (cur_type),
    .val_i  (val_q),
    .idx_i  (6'(ccur_q)),
    .last_i (ccur_q + 1'b1 == ccount_q),
    .item_o (col_item)
  );

  // Input is taken only when the output register is free, so each byte causes
  // at most one result in its own cycle.
  assign in_ready_o = !ov_q && (state_q == S_HSIZE || state_q == S_TYPES ||
                                state_q == S_BODY || state_q == S_DRAIN);
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    logic [63:0] nacc;
    logic [3:0]  ncnt;
    logic        vdone;
    logic [63:0] used;
    logic [31:0] nleft;
    logic [5:0]  tidx;
    logic        eflag;
    state_d    = state_q;
    vacc_d     = vacc_q;
    vcnt_d     = vcnt_q;
    hleft_d    = hleft_q;
    ccount_d   = ccount_q;
    ccur_d     = ccur_q;
    bleft_d    = bleft_q;
    val_d      = val_q;
    pend_end_d = pend_end_q;
    wr_en      = 1'b0;
    wr_idx     = ccount_q[IdxW-1:0];
    wr_data    = vacc_q[63:32] != 32'd0 ? 32'hffffffff : vacc_q[31:0];
    emit_v     = 1'b0;
    emit_item  = col_item;
    eflag      = in_data_i.end_of_payload;
    ncnt       = vcnt_q + 4'd1;
    if (ncnt >= 4'd9) begin
      nacc  = {vacc_q[55:0], in_data_i.data_byte};
      vdone = 1'b1;
    end else begin
      nacc  = {vacc_q[56:0], in_data_i.data_byte[6:0]};
      vdone = !in_data_i.data_byte[7];
    end
    used  = {60'd0, ncnt};
    nleft = hleft_q;
    tidx  = (ccount_q < CntW'(63)) ? 6'(ccount_q) : 6'd63;

    case (state_q)
      S_HSIZE: begin
        if (take) begin
          vacc_d = nacc;
          vcnt_d = ncnt;
          if (vdone) begin
            vacc_d   = '0;
            vcnt_d   = '0;
            ccount_d = '0;
            ccur_d   = '0;
            if (nacc <= used) begin
              state_d = S_DRAIN;
            end else begin
              hleft_d = (nacc - used) > 64'hffffffff ? 32'hffffffff
                                                      : 32'(nacc - used);
              state_d = S_TYPES;
            end
          end
          // An empty header ends the record quietly.
          if (eflag && !(vdone && nacc <= used)) begin
            emit_v    = 1'b1;
            emit_item = '0;
            emit_item.column_index = vdone ? 6'd0 : tidx;
            emit_item.kind         = KIND_TRUNCATED;
            emit_item.last_column  = 1'b1;
          end
        end
      end
      S_TYPES: begin
        if (take) begin
          if (hleft_q != 32'd0) nleft = hleft_q - 32'd1;
          hleft_d = nleft;
          vacc_d  = nacc;
          vcnt_d  = ncnt;
          if (vdone || nleft == 32'd0) begin
            if (ccount_q < CntW'(MAX_COLUMNS)) begin
              wr_en    = 1'b1;
              wr_data  = nacc[63:32] != 32'd0 ? 32'hffffffff : nacc[31:0];
              ccount_d = ccount_q + 1'b1;
            end
            vacc_d = '0;
            vcnt_d = '0;
          end
          if (nleft == 32'd0) begin
            ccur_d     = '0;
            state_d    = S_ADVANCE;
            pend_end_d = eflag;
          end else if (eflag) begin
            // The count includes a type stored by this very byte.
            emit_v    = 1'b1;
            emit_item = '0;
            emit_item.column_index = (ccount_d < CntW'(63)) ? 6'(ccount_d) : 6'd63;
            emit_item.kind         = KIND_TRUNCATED;
            emit_item.last_column  = 1'b1;
          end
        end
      end
      S_BODY: begin
        if (take) begin
          val_d   = {val_q[55:0], in_data_i.data_byte};
          bleft_d = (bleft_q != 32'd0) ? bleft_q - 32'd1 : bleft_q;
          if (bleft_d == 32'd0) begin
            state_d    = S_TRUNC;
            pend_end_d = eflag;
          end else if (eflag) begin
            emit_v    = 1'b1;
            emit_item = '0;
            emit_item.column_index = 6'(ccur_q);
            emit_item.kind         = KIND_TRUNCATED;
            emit_item.serial_type  = cur_type;
            emit_item.last_column  = 1'b1;
          end
        end
      end
      S_TRUNC: begin
        // Emit the column whose body was just completed.
        if (!ov_q) begin
          emit_v  = 1'b1;
          ccur_d  = ccur_q + 1'b1;
          state_d = S_ADVANCE;
        end
      end
      S_ADVANCE: begin
        if (!ov_q) begin
          if (ccur_q < ccount_q && cur_len == 32'd0) begin
            emit_v = 1'b1;
            ccur_d = ccur_q + 1'b1;
          end else if (ccur_q < ccount_q) begin
            bleft_d = cur_len;
            val_d   = '0;
            state_d = S_BODY;
            if (pend_end_q) begin
              emit_v    = 1'b1;
              emit_item = '0;
              emit_item.column_index = 6'(ccur_q);
              emit_item.kind         = KIND_TRUNCATED;
              emit_item.serial_type  = cur_type;
              emit_item.last_column  = 1'b1;
            end
          end else begin
            state_d = S_DRAIN;
          end
          if (pend_end_q && !(ccur_q < ccount_q && cur_len == 32'd0)) begin
            pend_end_d = 1'b0;
            state_d    = S_HSIZE;
            vacc_d     = '0;
            vcnt_d     = '0;
            hleft_d    = '0;
            ccount_d   = '0;
            ccur_d     = '0;
            bleft_d    = '0;
          end
        end
      end
      default: begin
      end
    endcase

    // An end flag on a byte that needs no further emit work restarts at once.
    if (take && eflag && !(state_d == S_ADVANCE || state_d == S_TRUNC)) begin
      state_d  = S_HSIZE;
      vacc_d   = '0;
      vcnt_d   = '0;
      hleft_d  = '0;
      ccount_d = '0;
      ccur_d   = '0;
      bleft_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= wr_data;
    end
    // A write to the entry being read is passed straight through.
    if (wr_en && wr_idx == rd_idx) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= store_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_HSIZE;
      vacc_q     <= '0;
      vcnt_q     <= '0;
      hleft_q    <= '0;
      ccount_q   <= '0;
      ccur_q     <= '0;
      bleft_q    <= '0;
      val_q      <= '0;
      pend_end_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      vacc_q     <= vacc_d;
      vcnt_q     <= vcnt_d;
      hleft_q    <= hleft_d;
      ccount_q   <= ccount_d;
      ccur_q     <= ccur_d;
      bleft_q    <= bleft_d;
      val_q      <= val_d;
      pend_end_q <= pend_end_d;
      if (emit_v) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_v) begin
      od_q <= emit_item;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  // A new result is only formed when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit_v |-> !ov_q)
    else $error("result formed over a waiting one");
  // Input is never taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni) take |-> !ov_q)
    else $error("byte taken while output busy");
  // The column cursor never passes the column count.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ccur_q <= ccount_q)
    else $error("column cursor beyond count");

endmodule

[sim/record_serial_type_decoder_tb.sv]
`timescale 1ns / 1ps

module record_serial_type_decoder_tb;
  import rstd_pkg::*;

  typedef enum logic [1:0] {
    PH_HDR_SIZE,
    PH_TYPES,
    PH_BODY,
    PH_SKIP
  } rec_phase_e;

  localparam int unsigned NumColumns = MaxColumnsDef;
  localparam int unsigned IdlePct    = 35;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  // When clear, both the sender and the receiver run without any gaps.
  bit idle_on = 1'b1;
  int errors = 0;
  int bytes_sent = 0;

  // Column results still to come out of the block, oldest first.
  out_item_t columns_due[$];

  // Shadow copy of the decoder state, updated at every accepted byte.
  rec_phase_e  rec_phase;
  logic [63:0] vi_acc;
  int unsigned vi_cnt;
  logic [31:0] hdr_left;
  logic [31:0] type_mem [NumColumns];
  int unsigned n_cols;
  int unsigned col_ptr;
  logic [31:0] body_left;
  logic [63:0] val_acc;

  record_serial_type_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Number of body bytes that a serial type occupies.
  function automatic logic [31:0] type_len(input logic [31:0] t);
    if (t >= 32'd12) return (t - 32'd12) >> 1;
    if (t >= 32'd1 && t <= 32'd4) return t;
    if (t == 32'd5) return 32'd6;
    if (t == 32'd6 || t == 32'd7) return 32'd8;
    return 32'd0;
  endfunction

  function automatic void start_record();
    rec_phase = PH_HDR_SIZE;
    vi_acc    = '0;
    vi_cnt    = 0;
    hdr_left  = '0;
    n_cols    = 0;
    col_ptr   = 0;
    body_left = '0;
    val_acc   = '0;
  endfunction

  // Feeds one byte into the varint; returns 1 when the varint is complete.
  // The ninth byte of a varint carries all eight of its bits.
  function automatic bit varint_feed(input logic [7:0] b);
    vi_cnt++;
    if (vi_cnt >= 9) begin
      vi_acc = (vi_acc << 8) + b;
      return 1'b1;
    end
    vi_acc = (vi_acc << 7) + b[6:0];
    return !b[7];
  endfunction

  // Builds the result for the column at col_ptr and moves to the next one.
  function automatic void emit_column(input logic [63:0] val);
    out_item_t   r;
    logic [31:0] t;
    logic [31:0] len;
    int unsigned bits;
    t   = type_mem[col_ptr];
    len = type_len(t);
    r   = '0;
    r.column_index = col_ptr[5:0];
    r.serial_type  = t;
    r.last_column  = (col_ptr + 1 == n_cols);
    r.kind         = KIND_RESERVED;
    if (t == 32'd0) begin
      r.kind = KIND_NULL;
    end else if (t <= 32'd6) begin
      bits = len * 8;
      r.kind = KIND_INTEGER;
      r.int_value = val;
      if (bits < 64 && val[bits-1]) r.int_value = val | ~((64'd1 << bits) - 64'd1);
    end else if (t == 32'd7) begin
      r.kind = KIND_FLOAT;
      r.float_bits = val;
    end else if (t == 32'd8 || t == 32'd9) begin
      r.kind = KIND_INTEGER;
      r.int_value = 64'(t - 32'd8);
    end else if (t >= 32'd12) begin
      r.kind = t[0] ? KIND_TEXT : KIND_BLOB;
      r.content_length = len[30:0];
    end
    columns_due.insert(columns_due.size(), r);
    col_ptr++;
  endfunction

  // Zero-length columns come out at once; then set up the next column with
  // a body, or skip to the end flag when none is left.
  function automatic void next_column();
    while (col_ptr < n_cols && type_len(type_mem[col_ptr]) == 0) emit_column('0);
    if (col_ptr >= n_cols) begin
      rec_phase = PH_SKIP;
    end else begin
      rec_phase = PH_BODY;
      body_left = type_len(type_mem[col_ptr]);
      val_acc   = '0;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic e);
    out_item_t   r;
    logic [63:0] rest;
    bit          done;
    bit          boundary;
    case (rec_phase)
      PH_HDR_SIZE: begin
        if (varint_feed(b)) begin
          n_cols  = 0;
          col_ptr = 0;
          if (vi_acc <= vi_cnt) begin
            // The header holds nothing past its own size field.
            rec_phase = PH_SKIP;
          end else begin
            rest = vi_acc - vi_cnt;
            hdr_left = (rest > 64'hffff_ffff) ? 32'hffff_ffff : rest[31:0];
            rec_phase = PH_TYPES;
          end
          vi_acc = '0;
          vi_cnt = 0;
        end
      end
      PH_TYPES: begin
        if (hdr_left > 0) hdr_left--;
        done = varint_feed(b);
        boundary = (hdr_left == 0);
        // A type cut off by the end of the header is kept as gathered so far.
        if (done || boundary) begin
          if (n_cols < NumColumns) begin
            type_mem[n_cols] = (vi_acc > 64'hffff_ffff) ? 32'hffff_ffff : vi_acc[31:0];
            n_cols++;
          end
          vi_acc = '0;
          vi_cnt = 0;
        end
        if (boundary) begin
          col_ptr = 0;
          next_column();
        end
      end
      PH_BODY: begin
        val_acc = (val_acc << 8) | b;
        if (body_left > 0) body_left--;
        if (body_left == 0) begin
          emit_column(val_acc);
          next_column();
        end
      end
      default: ;
    endcase
    if (e) begin
      r = '0;
      r.kind = KIND_TRUNCATED;
      r.last_column = 1'b1;
      if (rec_phase == PH_HDR_SIZE || rec_phase == PH_TYPES) begin
        r.column_index = (n_cols < 63) ? n_cols[5:0] : 6'd63;
        columns_due.insert(columns_due.size(), r);
      end else if (rec_phase == PH_BODY && col_ptr < n_cols) begin
        r.column_index = col_ptr[5:0];
        r.serial_type  = type_mem[col_ptr];
        columns_due.insert(columns_due.size(), r);
      end
      start_record();
    end
  endfunction

  // Sends one payload byte and updates the shadow state on its transfer.
  task automatic send_byte(input logic [7:0] b, input logic e);
    while (idle_on && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: b, end_of_payload: e};
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    decode_byte(b, e);
    bytes_sent++;
  endtask

  // Sends the first cut bytes of a payload, the end flag on the last of them.
  task automatic send_payload(input logic [7:0] q[$], input int cut);
    for (int i = 0; i < cut; i++) send_byte(q[i], i == cut - 1);
  endtask

  function automatic void add_varint(ref logic [7:0] q[$], input logic [63:0] v);
    int n;
    if ((v >> 56) != 0) begin
      for (int i = 0; i < 8; i++) begin
        q.insert(q.size(), 8'(8'h80 | ((v >> (8 + 7 * (7 - i))) & 64'h7f)));
      end
      q.insert(q.size(), v[7:0]);
      return;
    end
    n = 1;
    while ((v >> (7 * n)) != 0) n++;
    for (int i = n - 1; i >= 0; i--) begin
      q.insert(q.size(), 8'(((v >> (7 * i)) & 64'h7f) | (i != 0 ? 64'h80 : 64'h0)));
    end
  endfunction

  // Builds a well-formed payload for the given serial types. A fill value
  // below zero gives random body bytes.
  function automatic void build_record(ref logic [7:0] q[$], input logic [31:0] types[$],
                                       input int fill);
    logic [7:0] types_q[$];
    int         hsize;
    q.delete();
    foreach (types[i]) add_varint(types_q, types[i]);
    hsize = (types_q.size() + 1 < 128) ? types_q.size() + 1 : types_q.size() + 2;
    add_varint(q, 64'(hsize));
    q = {q, types_q};
    foreach (types[i]) begin
      for (int k = 0; k < type_len(types[i]); k++) begin
        q.insert(q.size(), fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
      end
    end
  endfunction

  function automatic logic [31:0] pick_type();
    int r;
    r = $urandom_range(0, 19);
    return (r < 12) ? 32'(r) : 32'(12 + $urandom_range(0, 20));
  endfunction

  // Serial types zero to fifteen, with the integer columns filled with sign extremes.
  task automatic test_column_kinds();
    logic [7:0]  q[$];
    logic [31:0] types[$];
    int          fills[2] = '{8'h80, 8'h7f};
    types = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15};
    foreach (fills[i]) begin
      build_record(q, types, fills[i]);
      send_payload(q, q.size());
    end
  endtask

  // Empty headers, header-end crossings, saturation and trailing bytes.
  task automatic test_header_edges();
    logic [7:0]  q[$];
    logic [31:0] types[$];
    // A header size of one or zero means no columns at all.
    q = '{8'h01, 8'h55, 8'haa};
    send_payload(q, q.size());
    q = '{8'h00};
    send_payload(q, q.size());
    // The second type byte still has its continuation bit when the header ends.
    q = '{8'h03, 8'h80, 8'h8e};
    q.insert(q.size(), 8'($urandom_range(0, 255)));
    send_payload(q, q.size());
    // A nine-byte serial type saturates; the huge blob is cut short.
    types = '{32'hffff_ffff};
    q.delete();
    q.insert(q.size(), 8'h0b);
    for (int i = 0; i < 9; i++) q.insert(q.size(), 8'hff);
    q = {q, 8'h00, 8'h11, 8'h22};
    send_payload(q, q.size());
    // A nine-byte header size saturates; the header itself is cut short.
    q.delete();
    for (int i = 0; i < 9; i++) q.insert(q.size(), 8'hff);
    q = {q, 8'h01, 8'h07, 8'h00};
    send_payload(q, q.size());
    // Bytes after the final column are skipped up to the end flag.
    types = '{1, 0};
    build_record(q, types, -1);
    q = {q, 8'hde, 8'had};
    send_payload(q, q.size());
  endtask

  // More serial types than the store holds: the extra ones are dropped.
  task automatic test_column_limit();
    logic [7:0]  q[$];
    logic [31:0] types[$];
    types.delete();
    for (int i = 0; i < 70; i++) types.insert(types.size(), 32'(i % 3 == 0 ? 8 : 0));
    build_record(q, types, -1);
    send_payload(q, q.size());
  endtask

  // The end flag lands in the header size, in the types and in the body.
  task automatic test_early_end();
    logic [7:0]  q[$];
    logic [31:0] types[$];
    q = '{8'h81};
    send_payload(q, 1);
    types = '{6, 7, 1};
    build_record(q, types, -1);
    send_payload(q, 2);
    send_payload(q, 6);
    send_payload(q, q.size() - 1);
  endtask

  // Mostly well-formed records with random content, some cut short, some noise.
  task automatic test_random_records(input int target);
    logic [7:0]  q[$];
    logic [31:0] types[$];
    int          sel;
    int          ncol;
    while (bytes_sent < target) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        q.delete();
        repeat ($urandom_range(1, 8)) q.insert(q.size(), 8'($urandom_range(0, 255)));
        send_payload(q, q.size());
      end else begin
        types.delete();
        ncol = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
        repeat (ncol) begin
          types.insert(types.size(), ncol > 8 ? 32'($urandom_range(0, 13)) : pick_type());
        end
        build_record(q, types, -1);
        send_payload(q, sel == 1 ? $urandom_range(1, q.size()) : q.size());
      end
    end
  endtask

  // The receiver stalls at random, except in the stretch with no idling.
  always @(posedge clk_i) begin
    out_ready_i <= !idle_on || ($urandom_range(0, 99) >= IdlePct);
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Outputs are stable at the falling edge; a transfer seen here completes
  // at the next rising edge.
  always @(negedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (columns_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, out_data_o);
        errors++;
      end else begin
        want = columns_due[0];
        columns_due.delete(0);
        check_field("column_index", 64'(want.column_index),
                    64'(out_data_o.column_index));
        check_field("kind", 64'(want.kind), 64'(out_data_o.kind));
        check_field("int_value", 64'(want.int_value), 64'(out_data_o.int_value));
        check_field("float_bits", want.float_bits, out_data_o.float_bits);
        check_field("content_length", 64'(want.content_length),
                    64'(out_data_o.content_length));
        check_field("serial_type", 64'(want.serial_type), 64'(out_data_o.serial_type));
        check_field("last_column", 64'(want.last_column), 64'(out_data_o.last_column));
      end
    end
  end

  initial begin
    start_record();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_column_kinds();
    test_header_edges();
    test_column_limit();
    test_early_end();
    test_random_records(bytes_sent + 15);
    // A stretch with no gaps on either side.
    idle_on = 1'b0;
    test_random_records(bytes_sent + 60);
    idle_on = 1'b1;
    test_random_records(bytes_sent + 15);
    in_valid_i <= 1'b0;
    while (columns_due.size() != 0) @(posedge clk_i);
    // The emit loop may still run over zero-length columns of the store.
    repeat (100) @(posedge clk_i);
    if (errors == 0 && columns_due.size() == 0) begin
      $display("record_serial_type_decoder_tb OK");
    end else begin
      $display("record_serial_type_decoder_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("record_serial_type_decoder_tb NOT OK");
    $finish;
  end

endmodule
